// File: src/assert_macros.svh
// assertion helpers for the collision resolver
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME_CYCLE(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT_CYCLE(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_SAME_CYCLE(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT_CYCLE(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/cpcr_pkg.sv
package cpcr_pkg;

    // field widths
    localparam int COORD_W    = 24;
    localparam int RAD_W      = 16;
    localparam int MASS_W     = 16;
    localparam int SUM_W      = RAD_W + 1;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * SUM_W;
    localparam int DSQ_W      = SQ_W + 2;
    localparam int ROOT_W     = DSQ_W / 2;
    localparam int FRAC_CFG_W = 17;
    localparam int CAP_W      = 20;
    localparam int OVL_CFG_W  = 16;
    localparam int FRAC_SHIFT = 16;
    localparam int PRAW_W     = SUM_W + FRAC_CFG_W;
    localparam int PUSH_W     = PRAW_W - FRAC_SHIFT;
    localparam int PW_W       = PUSH_W + MASS_W;
    localparam int NUM_W      = PW_W + SUM_W;
    localparam int DEN_W      = 2 * SUM_W;
    localparam int Q_W        = PUSH_W;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = Q_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = CAP_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRACTION = 3'd0,
        REG_CAP      = 3'd1,
        REG_SKIP     = 3'd2,
        REG_WAKE     = 3'd3
    } cfg_reg_t;

    localparam logic [FRAC_CFG_W-1:0] FRACTION_RST = 17'd49152;
    localparam logic [CAP_W-1:0]      CAP_RST      = 20'd32768;
    localparam logic [OVL_CFG_W-1:0]  SKIP_RST     = 16'd66;
    localparam logic [OVL_CFG_W-1:0]  WAKE_RST     = 16'd655;

    // squared distance below 0.001^2 counts as coincident centres
    localparam logic [DSQ_W-1:0] NEAR_DSQ_MIN = 36'd4295;

    // data carried alongside the arithmetic
    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic                      sx;
        logic                      sy;
        logic [SUM_W-1:0]          mag_x;
        logic [SUM_W-1:0]          mag_y;
        logic [SUM_W-1:0]          rsum;
        logic [SUM_W-1:0]          total;
        logic [MASS_W-1:0]         wa;
        logic [MASS_W-1:0]         wb;
        logic                      a_sl;
        logic                      b_sl;
        logic                      cand;
        logic                      hit;
        logic                      wake;
    } side_t;

    // add a signed move of magnitude q to a coordinate and saturate
    function automatic logic signed [COORD_W-1:0] sat_move(
        input logic signed [COORD_W-1:0] c,
        input logic [Q_W-1:0]            q,
        input logic                      neg
    );
        logic signed [COORD_W:0] mv;
        logic signed [COORD_W:0] sum;
        mv = $signed({{(COORD_W + 1 - Q_W){1'b0}}, q});
        if (neg)
            mv = -mv;
        sum = $signed({c[COORD_W-1], c}) + mv;
        if (sum[COORD_W] != sum[COORD_W-1])
            return sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        return sum[COORD_W-1:0];
    endfunction

endpackage

// File: src/cpcr_channels.sv
interface cpcr_pair_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cpcr_pkg::COORD_W-1:0]   a_x;
    logic signed [cpcr_pkg::COORD_W-1:0]   a_y;
    logic signed [cpcr_pkg::COORD_W-1:0]   b_x;
    logic signed [cpcr_pkg::COORD_W-1:0]   b_y;
    logic [cpcr_pkg::RAD_W-1:0]            a_radius;
    logic [cpcr_pkg::RAD_W-1:0]            b_radius;
    logic [cpcr_pkg::MASS_W-1:0]           a_mass;
    logic [cpcr_pkg::MASS_W-1:0]           b_mass;
    logic                                  a_sleeping;
    logic                                  b_sleeping;

    modport source (output valid, a_x, a_y, b_x, b_y, a_radius, b_radius, a_mass, b_mass,
                    a_sleeping, b_sleeping, input ready);
    modport sink (input valid, a_x, a_y, b_x, b_y, a_radius, b_radius, a_mass, b_mass,
                  a_sleeping, b_sleeping, output ready);
endinterface

interface cpcr_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cpcr_pkg::COORD_W-1:0]   new_a_x;
    logic signed [cpcr_pkg::COORD_W-1:0]   new_a_y;
    logic signed [cpcr_pkg::COORD_W-1:0]   new_b_x;
    logic signed [cpcr_pkg::COORD_W-1:0]   new_b_y;
    logic                                  moved;
    logic                                  a_woken;
    logic                                  b_woken;

    modport source (output valid, new_a_x, new_a_y, new_b_x, new_b_y, moved, a_woken,
                    b_woken, input ready);
    modport sink (input valid, new_a_x, new_a_y, new_b_x, new_b_y, moved, a_woken,
                  b_woken, output ready);
endinterface

// File: src/cpcr_isqrt.sv
module cpcr_isqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [cpcr_pkg::DSQ_W-1:0]    radicand,
    output logic [cpcr_pkg::ROOT_W-1:0]   root
);

    localparam int N     = cpcr_pkg::SQRT_STAGES;
    localparam int DW    = cpcr_pkg::DSQ_W;
    localparam int RW    = cpcr_pkg::ROOT_W;
    localparam int REM_W = RW + 2;

    logic [REM_W-1:0] rem_reg  [N];
    logic [RW-1:0]    root_reg [N];
    logic [DW-1:0]    rad_reg  [N];
    logic [REM_W-1:0] rem_next  [N];
    logic [RW-1:0]    root_next [N];
    logic [DW-1:0]    rad_next  [N];
    logic [REM_W-1:0] rem_src  [N];
    logic [RW-1:0]    root_src [N];
    logic [DW-1:0]    rad_src  [N];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            // stage sources
            if (g == 0) begin : g_first
                assign rem_src[g]  = '0;
                assign root_src[g] = '0;
                assign rad_src[g]  = radicand;
            end else begin : g_rest
                assign rem_src[g]  = rem_reg[g-1];
                assign root_src[g] = root_reg[g-1];
                assign rad_src[g]  = rad_reg[g-1];
            end

            // one root bit per stage from the next two radicand bits
            always_comb
            begin
                logic [REM_W+1:0] rem2;
                logic [REM_W+1:0] trial;
                logic [REM_W+1:0] diff;
                rem2  = {rem_src[g], rad_src[g][DW-1 -: 2]};
                trial = {2'b00, root_src[g], 2'b01};
                diff  = rem2 - trial;
                if (rem2 >= trial)
                begin
                    rem_next[g]  = diff[REM_W-1:0];
                    root_next[g] = {root_src[g][RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[g]  = rem2[REM_W-1:0];
                    root_next[g] = {root_src[g][RW-2:0], 1'b0};
                end
                rad_next[g] = {rad_src[g][DW-3:0], 2'b00};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g]  <= rem_next[g];
                    root_reg[g] <= root_next[g];
                    rad_reg[g]  <= rad_next[g];
                end
            end
        end
    endgenerate

    assign root = root_reg[N-1];

endmodule

// File: src/cpcr_div.sv
module cpcr_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [cpcr_pkg::NUM_W-1:0]    num,
    input  logic [cpcr_pkg::DEN_W-1:0]    den,
    output logic [cpcr_pkg::Q_W-1:0]      quo
);

    localparam int N  = cpcr_pkg::DIV_STAGES;
    localparam int QW = cpcr_pkg::Q_W;
    localparam int DW = cpcr_pkg::DEN_W;
    localparam int NW = cpcr_pkg::NUM_W;

    logic [DW-1:0] rem_reg [N];
    logic [QW-1:0] low_reg [N];
    logic [QW-1:0] q_reg   [N];
    logic [DW-1:0] den_reg [N];
    logic [DW-1:0] rem_next [N];
    logic [QW-1:0] low_next [N];
    logic [QW-1:0] q_next   [N];
    logic [DW-1:0] rem_src [N];
    logic [QW-1:0] low_src [N];
    logic [QW-1:0] q_src   [N];
    logic [DW-1:0] den_src [N];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            // quotient fits in QW bits, so the top numerator bits start below den
            if (g == 0) begin : g_first
                assign rem_src[g] = {{(DW - NW + QW){1'b0}}, num[NW-1:QW]};
                assign low_src[g] = num[QW-1:0];
                assign q_src[g]   = '0;
                assign den_src[g] = den;
            end else begin : g_rest
                assign rem_src[g] = rem_reg[g-1];
                assign low_src[g] = low_reg[g-1];
                assign q_src[g]   = q_reg[g-1];
                assign den_src[g] = den_reg[g-1];
            end

            // restoring step: one quotient bit
            always_comb
            begin
                logic [DW:0] r2;
                logic [DW:0] diff;
                logic        ge;
                r2   = {rem_src[g], low_src[g][QW-1]};
                diff = r2 - {1'b0, den_src[g]};
                ge   = (r2 >= {1'b0, den_src[g]});
                rem_next[g] = ge ? diff[DW-1:0] : r2[DW-1:0];
                q_next[g]   = {q_src[g][QW-2:0], ge};
                low_next[g] = {low_src[g][QW-2:0], 1'b0};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g] <= rem_next[g];
                    low_reg[g] <= low_next[g];
                    q_reg[g]   <= q_next[g];
                    den_reg[g] <= den_src[g];
                end
            end
        end
    endgenerate

    assign quo = q_reg[N-1];

endmodule

// File: src/circle_pair_collision_resolver_core.sv
// Circle pair collision resolver.
// Items enter on the pair channel (valid/ready) and leave on the result
// channel: one result item for every pair item, in order.
// The four settings are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle, which the block
// itself does not enforce. An index outside the register list is ignored.
// Pipeline: three front stages (differences, squares, range checks), an
// 18-stage square root with two radicand bits per stage, five stages for
// overlap, push and mass weighting, four 18-stage dividers with one
// quotient bit per stage, and the output register.
// One item can be accepted every cycle unless the output stalls.
// When the receiver holds result.ready low with a result waiting, the whole
// pipeline freezes and pair.ready drops; nothing is dropped or repeated.
// Reset clears all stage valid bits and loads the default settings.
`include "assert_macros.svh"

module circle_pair_collision_resolver_core (
    input  logic                                clk,
    input  logic                                rst_n,
    cpcr_pair_if.sink                           pair,
    cpcr_result_if.source                       result,
    input  logic                                cfg_we,
    input  logic [cpcr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cpcr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NS = cpcr_pkg::SQRT_STAGES;
    localparam int ND = cpcr_pkg::DIV_STAGES;
    localparam int CW = cpcr_pkg::COORD_W;
    localparam int SW = cpcr_pkg::SUM_W;

    // settings
    logic [cpcr_pkg::FRAC_CFG_W-1:0] frac_reg;
    logic [cpcr_pkg::CAP_W-1:0]      cap_reg;
    logic [cpcr_pkg::OVL_CFG_W-1:0]  skip_reg;
    logic [cpcr_pkg::OVL_CFG_W-1:0]  wake_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg <= cpcr_pkg::FRACTION_RST;
            cap_reg  <= cpcr_pkg::CAP_RST;
            skip_reg <= cpcr_pkg::SKIP_RST;
            wake_reg <= cpcr_pkg::WAKE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cpcr_pkg::cfg_reg_t'(cfg_index))
                cpcr_pkg::REG_FRACTION: frac_reg <= cfg_data[cpcr_pkg::FRAC_CFG_W-1:0];
                cpcr_pkg::REG_CAP:      cap_reg  <= cfg_data[cpcr_pkg::CAP_W-1:0];
                cpcr_pkg::REG_SKIP:     skip_reg <= cfg_data[cpcr_pkg::OVL_CFG_W-1:0];
                cpcr_pkg::REG_WAKE:     wake_reg <= cfg_data[cpcr_pkg::OVL_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: freeze everything while a result waits
    logic en;
    logic out_v_reg;
    assign en         = !out_v_reg || result.ready;
    assign pair.ready = en;

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic [NS-1:0] v_sq_reg;
    logic [ND-1:0] v_dv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v_sq_reg  <= '0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
            v7_reg    <= 1'b0;
            v8_reg    <= 1'b0;
            v_dv_reg  <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= pair.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v_sq_reg  <= {v_sq_reg[NS-2:0], v3_reg};
            v4_reg    <= v_sq_reg[NS-1];
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            v7_reg    <= v6_reg;
            v8_reg    <= v7_reg;
            v_dv_reg  <= {v_dv_reg[ND-2:0], v8_reg};
            out_v_reg <= v_dv_reg[ND-1];
        end
    end

    // stage 1: differences, radius sum, mass weights
    cpcr_pkg::side_t                   side1_reg, side1_next;
    logic signed [cpcr_pkg::DIFF_W-1:0] dx1_reg, dy1_reg, dx1_next, dy1_next;

    always_comb
    begin
        logic [SW-1:0] tot;
        side1_next      = '0;
        side1_next.ax   = pair.a_x;
        side1_next.ay   = pair.a_y;
        side1_next.bx   = pair.b_x;
        side1_next.by   = pair.b_y;
        side1_next.rsum = {1'b0, pair.a_radius} + {1'b0, pair.b_radius};
        side1_next.a_sl = pair.a_sleeping;
        side1_next.b_sl = pair.b_sleeping;
        tot = {1'b0, pair.a_mass} + {1'b0, pair.b_mass};
        // both masses zero: split the push evenly
        if (tot == '0)
        begin
            side1_next.wa    = cpcr_pkg::MASS_W'(1);
            side1_next.wb    = cpcr_pkg::MASS_W'(1);
            side1_next.total = SW'(2);
        end
        else
        begin
            side1_next.wa    = pair.b_mass;
            side1_next.wb    = pair.a_mass;
            side1_next.total = tot;
        end
        dx1_next = $signed({pair.a_x[CW-1], pair.a_x}) - $signed({pair.b_x[CW-1], pair.b_x});
        dy1_next = $signed({pair.a_y[CW-1], pair.a_y}) - $signed({pair.b_y[CW-1], pair.b_y});
    end

    // stage 2: magnitudes, axis gate, squares
    cpcr_pkg::side_t           side2_reg, side2_next;
    logic [cpcr_pkg::SQ_W-1:0] dxsq2_reg, dysq2_reg, rsq2_reg;
    logic [cpcr_pkg::SQ_W-1:0] dxsq2_next, dysq2_next, rsq2_next;

    always_comb
    begin
        logic [cpcr_pkg::DIFF_W-1:0] dxm;
        logic [cpcr_pkg::DIFF_W-1:0] dym;
        logic [cpcr_pkg::DIFF_W-1:0] rs_ext;
        side2_next    = side1_reg;
        dxm           = dx1_reg[cpcr_pkg::DIFF_W-1] ? -dx1_reg : dx1_reg;
        dym           = dy1_reg[cpcr_pkg::DIFF_W-1] ? -dy1_reg : dy1_reg;
        rs_ext        = {{(cpcr_pkg::DIFF_W - SW){1'b0}}, side1_reg.rsum};
        side2_next.sx    = dx1_reg[cpcr_pkg::DIFF_W-1];
        side2_next.sy    = dy1_reg[cpcr_pkg::DIFF_W-1];
        side2_next.mag_x = dxm[SW-1:0];
        side2_next.mag_y = dym[SW-1:0];
        side2_next.cand  = (dxm < rs_ext) && (dym < rs_ext);
        dxsq2_next = {{SW{1'b0}}, dxm[SW-1:0]} * {{SW{1'b0}}, dxm[SW-1:0]};
        dysq2_next = {{SW{1'b0}}, dym[SW-1:0]} * {{SW{1'b0}}, dym[SW-1:0]};
        rsq2_next  = {{SW{1'b0}}, side1_reg.rsum} * {{SW{1'b0}}, side1_reg.rsum};
    end

    // stage 3: squared distance, overlap and coincidence checks
    cpcr_pkg::side_t            side3_reg, side3_next;
    logic [cpcr_pkg::DSQ_W-1:0] dsq3_reg, dsq3_next;

    always_comb
    begin
        side3_next = side2_reg;
        dsq3_next  = {2'b00, dxsq2_reg} + {2'b00, dysq2_reg};
        side3_next.cand = side2_reg.cand && (dsq3_next < {2'b00, rsq2_reg})
                          && (dsq3_next >= cpcr_pkg::NEAR_DSQ_MIN);
    end

    // square root pipeline
    logic [cpcr_pkg::ROOT_W-1:0] root;
    cpcr_pkg::side_t             side_sq_reg [NS];

    cpcr_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (dsq3_reg),
        .root     (root)
    );

    // stage 4: overlap, skip and wake decisions
    cpcr_pkg::side_t side4_reg, side4_next;
    logic [SW-1:0]   ov4_reg, ov4_next, dist4_reg;

    always_comb
    begin
        logic [cpcr_pkg::ROOT_W-1:0] ov_full;
        side4_next = side_sq_reg[NS-1];
        ov_full    = {1'b0, side_sq_reg[NS-1].rsum} - root;
        ov4_next   = ov_full[SW-1:0];
        side4_next.hit  = side_sq_reg[NS-1].cand && (ov4_next >= {1'b0, skip_reg})
                          && (root != '0);
        side4_next.wake = ov4_next > {1'b0, wake_reg};
    end

    // stage 5: raw push and divisor
    cpcr_pkg::side_t             side5_reg;
    logic [cpcr_pkg::PRAW_W-1:0] praw5_reg;
    logic [cpcr_pkg::DEN_W-1:0]  den5_reg;

    // stage 6: capped push
    cpcr_pkg::side_t             side6_reg;
    logic [cpcr_pkg::PUSH_W-1:0] push6_reg, push6_next;
    logic [cpcr_pkg::DEN_W-1:0]  den6_reg;

    always_comb
    begin
        logic [cpcr_pkg::PUSH_W-1:0] p;
        p = praw5_reg[cpcr_pkg::PRAW_W-1:cpcr_pkg::FRAC_SHIFT];
        if ({{(cpcr_pkg::CAP_W - cpcr_pkg::PUSH_W){1'b0}}, p} > cap_reg)
            push6_next = cap_reg[cpcr_pkg::PUSH_W-1:0];
        else
            push6_next = p;
    end

    // stage 7: push times mass weight
    cpcr_pkg::side_t            side7_reg;
    logic [cpcr_pkg::PW_W-1:0]  pwa7_reg, pwb7_reg;
    logic [cpcr_pkg::DEN_W-1:0] den7_reg;

    // stage 8: numerators
    cpcr_pkg::side_t            side8_reg;
    logic [cpcr_pkg::NUM_W-1:0] nax8_reg, nay8_reg, nbx8_reg, nby8_reg;
    logic [cpcr_pkg::DEN_W-1:0] den8_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side1_next;
            dx1_reg   <= dx1_next;
            dy1_reg   <= dy1_next;
            side2_reg <= side2_next;
            dxsq2_reg <= dxsq2_next;
            dysq2_reg <= dysq2_next;
            rsq2_reg  <= rsq2_next;
            side3_reg <= side3_next;
            dsq3_reg  <= dsq3_next;
            side_sq_reg[0] <= side3_reg;
            for (int i = 1; i < NS; i++)
                side_sq_reg[i] <= side_sq_reg[i-1];
            side4_reg <= side4_next;
            ov4_reg   <= ov4_next;
            dist4_reg <= root[SW-1:0];
            side5_reg <= side4_reg;
            praw5_reg <= {{cpcr_pkg::FRAC_CFG_W{1'b0}}, ov4_reg}
                         * {{SW{1'b0}}, frac_reg};
            den5_reg  <= {{SW{1'b0}}, side4_reg.total} * {{SW{1'b0}}, dist4_reg};
            side6_reg <= side5_reg;
            push6_reg <= push6_next;
            den6_reg  <= den5_reg;
            side7_reg <= side6_reg;
            pwa7_reg  <= {{cpcr_pkg::MASS_W{1'b0}}, push6_reg}
                         * {{cpcr_pkg::PUSH_W{1'b0}}, side6_reg.wa};
            pwb7_reg  <= {{cpcr_pkg::MASS_W{1'b0}}, push6_reg}
                         * {{cpcr_pkg::PUSH_W{1'b0}}, side6_reg.wb};
            den7_reg  <= den6_reg;
            side8_reg <= side7_reg;
            nax8_reg  <= {{SW{1'b0}}, pwa7_reg} * {{cpcr_pkg::PW_W{1'b0}}, side7_reg.mag_x};
            nay8_reg  <= {{SW{1'b0}}, pwa7_reg} * {{cpcr_pkg::PW_W{1'b0}}, side7_reg.mag_y};
            nbx8_reg  <= {{SW{1'b0}}, pwb7_reg} * {{cpcr_pkg::PW_W{1'b0}}, side7_reg.mag_x};
            nby8_reg  <= {{SW{1'b0}}, pwb7_reg} * {{cpcr_pkg::PW_W{1'b0}}, side7_reg.mag_y};
            den8_reg  <= den7_reg;
        end
    end

    // four move dividers sharing one divisor
    logic [cpcr_pkg::Q_W-1:0] qax, qay, qbx, qby;
    cpcr_pkg::side_t          side_dv_reg [ND];

    cpcr_div u_div_ax (.clk(clk), .en(en), .num(nax8_reg), .den(den8_reg), .quo(qax));
    cpcr_div u_div_ay (.clk(clk), .en(en), .num(nay8_reg), .den(den8_reg), .quo(qay));
    cpcr_div u_div_bx (.clk(clk), .en(en), .num(nbx8_reg), .den(den8_reg), .quo(qbx));
    cpcr_div u_div_by (.clk(clk), .en(en), .num(nby8_reg), .den(den8_reg), .quo(qby));

    // output stage: apply moves with saturation
    cpcr_pkg::side_t          sd;
    logic [cpcr_pkg::Q_W-1:0] mqax, mqay, mqbx, mqby;
    logic signed [CW-1:0]     nax_reg, nay_reg, nbx_reg, nby_reg;
    logic                     moved_reg, aw_reg, bw_reg;

    assign sd   = side_dv_reg[ND-1];
    assign mqax = sd.hit ? qax : '0;
    assign mqay = sd.hit ? qay : '0;
    assign mqbx = sd.hit ? qbx : '0;
    assign mqby = sd.hit ? qby : '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dv_reg[0] <= side8_reg;
            for (int i = 1; i < ND; i++)
                side_dv_reg[i] <= side_dv_reg[i-1];
            nax_reg   <= cpcr_pkg::sat_move(sd.ax, mqax, sd.sx);
            nay_reg   <= cpcr_pkg::sat_move(sd.ay, mqay, sd.sy);
            nbx_reg   <= cpcr_pkg::sat_move(sd.bx, mqbx, !sd.sx);
            nby_reg   <= cpcr_pkg::sat_move(sd.by, mqby, !sd.sy);
            moved_reg <= sd.hit;
            aw_reg    <= sd.hit && sd.wake && sd.a_sl;
            bw_reg    <= sd.hit && sd.wake && sd.b_sl;
        end
    end

    assign result.valid   = out_v_reg;
    assign result.new_a_x = nax_reg;
    assign result.new_a_y = nay_reg;
    assign result.new_b_x = nbx_reg;
    assign result.new_b_y = nby_reg;
    assign result.moved   = moved_reg;
    assign result.a_woken = aw_reg;
    assign result.b_woken = bw_reg;

    // pipeline occupancy for checks
    logic [7:0] v_front;
    assign v_front = {v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg};

    `ASSERT_SAME_CYCLE(a_wake_needs_move, clk, rst_n, result.valid && (result.a_woken || result.b_woken), result.moved, "woken circle without a move")
    `ASSERT_NEXT_CYCLE(a_stall_freezes_front, clk, rst_n, !en, $stable(v_front) && $stable(v_sq_reg), "front stages moved during stall")
    `ASSERT_NEXT_CYCLE(a_stall_freezes_back, clk, rst_n, !en, $stable(v_dv_reg) && $stable(out_v_reg), "back stages moved during stall")
    `ASSERT_SAME_CYCLE(a_hit_from_candidate, clk, rst_n, v4_reg && side4_reg.hit, side4_reg.cand && (dist4_reg != '0), "move on a pair that was not a candidate")

endmodule

// File: bench/circle_pair_collision_resolver_core_test.sv
module circle_pair_collision_resolver_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam longint CMAX = (64'sd1 <<< (cpcr_pkg::COORD_W - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;

    typedef struct {
        logic signed [cpcr_pkg::COORD_W-1:0] a_x, a_y, b_x, b_y;
        logic [cpcr_pkg::RAD_W-1:0]          a_radius, b_radius;
        logic [cpcr_pkg::MASS_W-1:0]         a_mass, b_mass;
        logic                                a_sleeping, b_sleeping;
    } pair_item_t;

    typedef struct {
        logic signed [cpcr_pkg::COORD_W-1:0] new_a_x, new_a_y, new_b_x, new_b_y;
        logic                                moved, a_woken, b_woken;
    } placement_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [cpcr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cpcr_pkg::CFG_DATA_W-1:0] cfg_data;

    cpcr_pair_if pair_ch();
    cpcr_result_if res_ch();

    circle_pair_collision_resolver_core DUT (
        .clk(clk), .rst_n(rst_n), .pair(pair_ch), .result(res_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // settings as the block should hold them
    longint unsigned fraction_set, cap_set, skip_set, wake_set;

    pair_item_t pending_pairs[$];
    placement_t expected_placements[$];
    pair_item_t on_wire;
    int src_idle = 0;
    int rcv_stall = 0;
    int errors = 0;
    int cycles = 0;

    always #1 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint share_move(longint unsigned push, longint unsigned weight,
                                          longint d, longint unsigned denom);
        longint unsigned mag = (d < 0) ? longint'(-d) : longint'(d);
        longint unsigned q;
        if (denom == 0)
            return 0;
        q = (push * weight * mag) / denom;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [cpcr_pkg::COORD_W-1:0] clamp_coord(longint v);
        if (v > CMAX)
            v = CMAX;
        if (v < CMIN)
            v = CMIN;
        return v[cpcr_pkg::COORD_W-1:0];
    endfunction

    // expected placement of one pair under the current settings
    function automatic placement_t resolve_pair(pair_item_t p);
        placement_t r;
        longint ax = p.a_x, ay = p.a_y, bx = p.b_x, by = p.b_y;
        longint dx = ax - bx;
        longint dy = ay - by;
        longint rsum = longint'(p.a_radius) + longint'(p.b_radius);
        longint unsigned dsq, rsq, spacing, overlap, push, wa, wb, total;
        r.moved = 1'b0;
        r.a_woken = 1'b0;
        r.b_woken = 1'b0;
        if (dx < rsum && -dx < rsum && dy < rsum && -dy < rsum)
        begin
            dsq = dx * dx + dy * dy;
            rsq = rsum * rsum;
            if (dsq < rsq && !(dsq * 1000000 < (64'd1 << 32)))
            begin
                spacing = int_sqrt(dsq);
                overlap = rsum - spacing;
                if (overlap >= skip_set && spacing != 0)
                begin
                    push = (overlap * fraction_set) >> 16;
                    if (push > cap_set)
                        push = cap_set;
                    total = longint'(p.a_mass) + longint'(p.b_mass);
                    if (total == 0)
                    begin
                        wa = 1;
                        wb = 1;
                        total = 2;
                    end
                    else
                    begin
                        wa = p.b_mass;
                        wb = p.a_mass;
                    end
                    ax += share_move(push, wa, dx, total * spacing);
                    ay += share_move(push, wa, dy, total * spacing);
                    bx -= share_move(push, wb, dx, total * spacing);
                    by -= share_move(push, wb, dy, total * spacing);
                    r.moved = 1'b1;
                    if (overlap > wake_set)
                    begin
                        r.a_woken = p.a_sleeping;
                        r.b_woken = p.b_sleeping;
                    end
                end
            end
        end
        r.new_a_x = clamp_coord(ax);
        r.new_a_y = clamp_coord(ay);
        r.new_b_x = clamp_coord(bx);
        r.new_b_y = clamp_coord(by);
        return r;
    endfunction

    // pair driver: predicts each accepted item, then offers the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pair_ch.valid <= 1'b0;
        else
        begin
            if (pair_ch.valid && pair_ch.ready)
                expected_placements = {expected_placements, resolve_pair(on_wire)};
            if (!pair_ch.valid || pair_ch.ready)
            begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= src_idle)
                begin
                    on_wire = pending_pairs.pop_front();
                    pair_ch.a_x <= on_wire.a_x;
                    pair_ch.a_y <= on_wire.a_y;
                    pair_ch.b_x <= on_wire.b_x;
                    pair_ch.b_y <= on_wire.b_y;
                    pair_ch.a_radius <= on_wire.a_radius;
                    pair_ch.b_radius <= on_wire.b_radius;
                    pair_ch.a_mass <= on_wire.a_mass;
                    pair_ch.b_mass <= on_wire.b_mass;
                    pair_ch.a_sleeping <= on_wire.a_sleeping;
                    pair_ch.b_sleeping <= on_wire.b_sleeping;
                    pair_ch.valid <= 1'b1;
                end
                else
                    pair_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        placement_t want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_placements.size() == 0)
                begin
                    $error("result item with no pair waiting");
                    errors++;
                end
                else
                begin
                    want = expected_placements.pop_front();
                    if (res_ch.new_a_x !== want.new_a_x)
                    begin
                        $error("new_a_x expected %0d got %0d", want.new_a_x, res_ch.new_a_x);
                        errors++;
                    end
                    if (res_ch.new_a_y !== want.new_a_y)
                    begin
                        $error("new_a_y expected %0d got %0d", want.new_a_y, res_ch.new_a_y);
                        errors++;
                    end
                    if (res_ch.new_b_x !== want.new_b_x)
                    begin
                        $error("new_b_x expected %0d got %0d", want.new_b_x, res_ch.new_b_x);
                        errors++;
                    end
                    if (res_ch.new_b_y !== want.new_b_y)
                    begin
                        $error("new_b_y expected %0d got %0d", want.new_b_y, res_ch.new_b_y);
                        errors++;
                    end
                    if (res_ch.moved !== want.moved)
                    begin
                        $error("moved expected %0b got %0b", want.moved, res_ch.moved);
                        errors++;
                    end
                    if (res_ch.a_woken !== want.a_woken)
                    begin
                        $error("a_woken expected %0b got %0b", want.a_woken, res_ch.a_woken);
                        errors++;
                    end
                    if (res_ch.b_woken !== want.b_woken)
                    begin
                        $error("b_woken expected %0b got %0b", want.b_woken, res_ch.b_woken);
                        errors++;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= rcv_stall);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_setting(cpcr_pkg::cfg_reg_t idx,
                                 logic [cpcr_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            cpcr_pkg::REG_FRACTION: fraction_set = value & 20'h1FFFF;
            cpcr_pkg::REG_CAP:      cap_set = value;
            cpcr_pkg::REG_SKIP:     skip_set = value & 20'hFFFF;
            cpcr_pkg::REG_WAKE:     wake_set = value & 20'hFFFF;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_pair(longint ax, longint ay, longint bx, longint by,
                            int ar, int br, int am, int bm, bit as, bit bs);
        pair_item_t p;
        p.a_x = cpcr_pkg::COORD_W'(ax);
        p.a_y = cpcr_pkg::COORD_W'(ay);
        p.b_x = cpcr_pkg::COORD_W'(bx);
        p.b_y = cpcr_pkg::COORD_W'(by);
        p.a_radius = cpcr_pkg::RAD_W'(ar);
        p.b_radius = cpcr_pkg::RAD_W'(br);
        p.a_mass = cpcr_pkg::MASS_W'(am);
        p.b_mass = cpcr_pkg::MASS_W'(bm);
        p.a_sleeping = as;
        p.b_sleeping = bs;
        pending_pairs = {pending_pairs, p};
    endtask

    // mostly touching pairs with random content, some coincident, some far
    task automatic add_random_pairs(int count);
        int ar, br, rs, kind;
        longint ax, ay, dx, dy, span;
        repeat (count)
        begin
            ar = $urandom_range(0, 65535);
            br = $urandom_range(0, 65535);
            if ($urandom_range(3) == 0)
            begin
                ar = ar >> $urandom_range(15);
                br = br >> $urandom_range(15);
            end
            rs = ar + br + 1;
            kind = $urandom_range(99);
            span = (64'sd1 <<< 23) - 262144;
            ax = longint'($urandom_range(0, 2 * span)) - span;
            ay = longint'($urandom_range(0, 2 * span)) - span;
            if (kind < 5)
            begin
                // push against the coordinate limits
                ax = ($urandom_range(1) == 1) ? CMAX - $urandom_range(0, 1000)
                                              : CMIN + $urandom_range(0, 1000);
                ay = ($urandom_range(1) == 1) ? CMAX - $urandom_range(0, 1000)
                                              : CMIN + $urandom_range(0, 1000);
            end
            if (kind < 75)
            begin
                dx = longint'($urandom_range(0, 2 * rs)) - rs;
                dy = longint'($urandom_range(0, 2 * rs)) - rs;
            end
            else if (kind < 85)
            begin
                dx = longint'($urandom_range(0, 130)) - 65;
                dy = longint'($urandom_range(0, 130)) - 65;
            end
            else if (kind < 92)
            begin
                dx = rs + $urandom_range(0, 3);
                dy = longint'($urandom_range(0, 2 * rs)) - rs;
            end
            else
            begin
                add_pair($signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8,
                         $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8,
                         $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8,
                         $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8,
                         ar, br, $urandom_range(1, 65535), $urandom_range(1, 65535),
                         $urandom_range(1), $urandom_range(1));
                continue;
            end
            // keep the second centre in range
            if (ax - dx > CMAX || ax - dx < CMIN)
                dx = -dx;
            if (ay - dy > CMAX || ay - dy < CMIN)
                dy = -dy;
            add_pair(ax, ay, ax - dx, ay - dy, ar, br,
                     ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 65535),
                     ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 65535),
                     $urandom_range(1), $urandom_range(1));
        end
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || pair_ch.valid || expected_placements.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pair_ch.valid = 1'b0;
        {pair_ch.a_x, pair_ch.a_y, pair_ch.b_x, pair_ch.b_y} = '0;
        {pair_ch.a_radius, pair_ch.b_radius, pair_ch.a_mass, pair_ch.b_mass} = '0;
        {pair_ch.a_sleeping, pair_ch.b_sleeping} = '0;
        res_ch.ready = 1'b0;
        fraction_set = cpcr_pkg::FRACTION_RST;
        cap_set = cpcr_pkg::CAP_RST;
        skip_set = cpcr_pkg::SKIP_RST;
        wake_set = cpcr_pkg::WAKE_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pairs at reset settings, no idling
        add_pair(CMAX, CMAX, CMIN, CMIN, 65535, 65535, 65535, 65535, 1, 1);
        add_pair(0, 0, 1000, 0, 500, 500, 65536 / 2, 65536 / 2, 1, 1);
        add_pair(0, 0, 1000, 0, 600, 600, 100, 200, 1, 1);
        add_pair(0, 0, 950, 0, 500, 500, 100, 100, 1, 1);
        add_pair(5, -3, 5, -3, 1000, 1000, 1, 1, 0, 1);
        add_pair(10, 10, 40, 50, 1000, 1000, 1, 1, 1, 0);
        add_pair(CMAX, 0, CMAX - 65536, 0, 65535, 65535, 1, 65535, 1, 1);
        add_pair(CMIN, CMIN, CMIN + 1000, CMIN + 1000, 65535, 65535, 65535, 1, 0, 0);
        add_pair(0, 0, 0, 70000, 65535, 65535, 300, 300, 1, 1);
        add_pair(-70000, 3000, 0, 0, 40000, 40000, 65535, 1, 1, 1);
        add_pair(0, 0, 300, 300, 0, 0, 1, 1, 1, 1);
        add_pair(0, 0, 65000, 0, 65535, 0, 1, 1, 1, 1);
        add_pair(0, 0, 0, -900, 500, 500, 7, 9, 0, 1);
        add_pair(0, 0, 100, 0, 300, 300, 1, 1, 1, 1);
        add_random_pairs(300);
        wait_drained();

        // widest settings, sender idle
        write_setting(cpcr_pkg::REG_FRACTION, 20'hF0000 | 20'd65536);
        write_setting(cpcr_pkg::REG_CAP, 20'hFFFFF);
        write_setting(cpcr_pkg::REG_SKIP, 20'hF0000);
        write_setting(cpcr_pkg::REG_WAKE, 20'h00000);
        src_idle = 75;
        add_random_pairs(310);
        wait_drained();

        // everything at zero or full skip, receiver stalling
        write_setting(cpcr_pkg::REG_FRACTION, 20'd0);
        write_setting(cpcr_pkg::REG_CAP, 20'd0);
        write_setting(cpcr_pkg::REG_SKIP, 20'd65535);
        write_setting(cpcr_pkg::REG_WAKE, 20'd65535);
        src_idle = 0;
        rcv_stall = 75;
        add_random_pairs(310);
        wait_drained();

        // random settings, both sides idling, with a pause to drain midway
        write_setting(cpcr_pkg::REG_FRACTION, cpcr_pkg::CFG_DATA_W'($urandom_range(0, 65536)));
        write_setting(cpcr_pkg::REG_CAP, cpcr_pkg::CFG_DATA_W'($urandom_range(0, 200000)));
        write_setting(cpcr_pkg::REG_SKIP, cpcr_pkg::CFG_DATA_W'($urandom_range(0, 3000)));
        write_setting(cpcr_pkg::REG_WAKE, cpcr_pkg::CFG_DATA_W'($urandom_range(0, 8000)));
        src_idle = 20;
        rcv_stall = 20;
        add_random_pairs(150);
        wait_drained();
        add_random_pairs(160);
        wait_drained();

        // back to defaults with small cap, no idling
        write_setting(cpcr_pkg::REG_FRACTION, cpcr_pkg::CFG_DATA_W'(cpcr_pkg::FRACTION_RST));
        write_setting(cpcr_pkg::REG_CAP, cpcr_pkg::CFG_DATA_W'($urandom_range(1, 4000)));
        write_setting(cpcr_pkg::REG_SKIP, cpcr_pkg::CFG_DATA_W'(cpcr_pkg::SKIP_RST));
        write_setting(cpcr_pkg::REG_WAKE, cpcr_pkg::CFG_DATA_W'(cpcr_pkg::WAKE_RST));
        src_idle = 0;
        rcv_stall = 0;
        add_random_pairs(310);
        wait_drained();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+src
src/cpcr_pkg.sv
src/cpcr_channels.sv
src/cpcr_isqrt.sv
src/cpcr_div.sv
src/circle_pair_collision_resolver_core.sv
bench/circle_pair_collision_resolver_core_test.sv
